[hw/rtl/periodic_job_timer_table_assert.svh]
// Assertion macros shared by the periodic job timer table RTL.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef PERIODIC_JOB_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_JOB_TIMER_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising clock edge outside reset.
`define PJTT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define PJTT_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PJTT_ASSERT(label, clk, rst, prop, msg)
`define PJTT_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

[hw/rtl/pjtt_pkg.sv]
// Package for the periodic job timer table: sizes, codes and beat types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pjtt_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int RES_SLOT_W  = 4;

  // Command kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // Result kinds
  localparam logic [1:0] RES_ADDED = 2'd0;
  localparam logic [1:0] RES_FULL  = 2'd1;
  localparam logic [1:0] RES_FIRED = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ticks;
    logic [15:0] job_tag;
    logic [31:0] first_delay;
    logic [31:0] repeat_period;
    logic [3:0]  slot_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]            result_kind;
    logic [RES_SLOT_W-1:0] slot;
    logic [15:0]           tag;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] duration;
    logic [31:0] period;
    logic [15:0] tag;
  } entry_t;

endpackage

`default_nettype wire

[hw/rtl/pjtt_entry_ram.sv]
// Slot entry memory: start, duration, period and tag of every timer slot.
// One write port, one read port with registered read data; uses pjtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pjtt_entry_ram (
  input  wire                        clk,
  input  wire                        we,
  input  wire  [pjtt_pkg::SLOT_W-1:0] waddr,
  input  pjtt_pkg::entry_t           wdata,
  input  wire  [pjtt_pkg::SLOT_W-1:0] raddr,
  output pjtt_pkg::entry_t           rdata
);
  import pjtt_pkg::*;

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/pjtt_slot_alloc.sv]
// Free slot finder: lowest-numbered slot whose busy bit is clear.
// Pure combinational priority encoder; uses pjtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pjtt_slot_alloc (
  input  wire  [pjtt_pkg::SLOTS-1:0]  busy_bits,
  output logic                        found,
  output logic [pjtt_pkg::SLOT_W-1:0] idx
);
  import pjtt_pkg::*;

  always_comb begin
    found = 1'b0;
    idx   = '0;
    // walk downward so the lowest free slot wins
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_bits[i]) begin
        found = 1'b1;
        idx   = SLOT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/periodic_job_timer_table.sv]
// Periodic job timer table, top level: command decode, tick scan, result beats.
// Uses pjtt_pkg, pjtt_entry_ram, pjtt_slot_alloc and the assertion header.
//
// Usage:
//   Drive cmd and raise start; a command beat is taken at an edge where start
//   is high and busy is low. Result beats come out on result, each valid for
//   exactly one cycle while result_valid is high; the receiver cannot stall
//   them, so it must take every beat as it comes.
//   Add: one result beat (job added with its slot, or table full) in the cycle
//   after the command is taken; busy stays low, so commands can stream.
//   Remove: no result; busy stays low.
//   Tick: busy is high through the scan and the flush that follows it. The scan
//   reads one slot entry per cycle from the entry memory, so the scan length
//   is set by that single read port. Each fired beat is held until the next
//   firing or the end of the scan settles its last flag; the final one, marked
//   by last, is out in the first cycle with busy low.
//   A tick with nothing due gives no beat.
// Reset: synchronous, active high; marks every slot free. Slot entries need
// no clearing since an entry is only used for a busy slot, which its add wrote.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_job_timer_table_assert.svh"

module periodic_job_timer_table (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  pjtt_pkg::cmd_t    cmd,
  output pjtt_pkg::result_t result,
  output logic              result_valid
);
  import pjtt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  state_t            state;
  logic [SLOTS-1:0]  busy_bits;
  cmd_t              cmd_q;

  // scan pipeline: issue stage drives the read address, eval stage sees data
  logic              issue_active;
  logic [SLOT_W-1:0] issue_idx;
  logic              eval_valid;
  logic [SLOT_W-1:0] eval_idx;
  logic [CNT_W-1:0]  fire_cnt;

  // one fired beat is held back until we know whether another follows it
  logic              hold_valid;
  logic [SLOT_W-1:0] hold_slot;
  logic [15:0]       hold_tag;

  logic              accept;
  logic              alloc_found;
  logic [SLOT_W-1:0] alloc_idx;
  logic              add_take;
  logic [31:0]       elapsed;
  logic              fire;
  logic              rearm;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  entry_t            rd_entry;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  pjtt_slot_alloc u_alloc (
    .busy_bits (busy_bits),
    .found     (alloc_found),
    .idx       (alloc_idx)
  );

  pjtt_entry_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_idx),
    .rdata (rd_entry)
  );

  // Due test on the entry read last cycle; drop firings past the result cap.
  assign elapsed = cmd_q.now_ticks - rd_entry.start;
  assign fire    = (state == S_SCAN) && eval_valid && busy_bits[eval_idx] &&
                   (elapsed >= rd_entry.duration) && (fire_cnt < CNT_W'(MAX_RESULTS));
  assign rearm   = fire && (rd_entry.period != '0);
  assign add_take = accept && (cmd.kind == KIND_ADD) && alloc_found;

  // Write port: adds happen only while idle and rearms only while scanning,
  // and each slot is read once then written at most once per scan, so no forwarding.
  always_comb begin
    ram_we    = add_take || rearm;
    ram_waddr = eval_idx;
    ram_wdata = '{start: cmd_q.now_ticks, duration: rd_entry.period,
                  period: rd_entry.period, tag: rd_entry.tag};
    if (state == S_IDLE) begin
      ram_waddr = alloc_idx;
      ram_wdata = '{start: cmd.now_ticks, duration: cmd.first_delay,
                    period: cmd.repeat_period, tag: cmd.job_tag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      busy_bits    <= '0;
      issue_active <= 1'b0;
      eval_valid   <= 1'b0;
      hold_valid   <= 1'b0;
      fire_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      eval_valid   <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.kind)
              KIND_ADD: begin
                // claim the lowest free slot, or report the table full
                result_valid <= 1'b1;
                if (alloc_found) begin
                  busy_bits[alloc_idx] <= 1'b1;
                  result <= '{result_kind: RES_ADDED, slot: RES_SLOT_W'(alloc_idx),
                              tag: '0, last: 1'b1};
                end else begin
                  result <= '{result_kind: RES_FULL, slot: '0, tag: '0, last: 1'b1};
                end
              end
              KIND_REMOVE: begin
                if (32'(cmd.slot_index) < SLOTS) begin
                  busy_bits[SLOT_W'(cmd.slot_index)] <= 1'b0;
                end
              end
              KIND_TICK: begin
                state        <= S_SCAN;
                cmd_q        <= cmd;
                issue_idx    <= '0;
                issue_active <= 1'b1;
                fire_cnt     <= '0;
                hold_valid   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          // advance the read address one slot per cycle
          if (issue_active) begin
            eval_valid <= 1'b1;
            eval_idx   <= issue_idx;
            if (issue_idx == LAST_SLOT) begin
              issue_active <= 1'b0;
            end else begin
              issue_idx <= issue_idx + 1'b1;
            end
          end
          if (eval_valid) begin
            if (fire) begin
              fire_cnt <= fire_cnt + 1'b1;
              if (!rearm) begin
                busy_bits[eval_idx] <= 1'b0;
              end
              // a newer firing exists, so release the held beat as not last
              if (hold_valid) begin
                result_valid <= 1'b1;
                result <= '{result_kind: RES_FIRED, slot: RES_SLOT_W'(hold_slot),
                            tag: hold_tag, last: 1'b0};
              end
              hold_valid <= 1'b1;
              hold_slot  <= eval_idx;
              hold_tag   <= rd_entry.tag;
            end
            if (eval_idx == LAST_SLOT) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          // scan done: the held beat is the final one
          if (hold_valid) begin
            result_valid <= 1'b1;
            result <= '{result_kind: RES_FIRED, slot: RES_SLOT_W'(hold_slot),
                        tag: hold_tag, last: 1'b1};
          end
          hold_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PJTT_ASSERT(a_add_gives_last, clk, rst,
               (accept && cmd.kind == KIND_ADD) |=> (result_valid && result.last),
               "add must give one final beat")
  `PJTT_ASSERT(a_remove_silent, clk, rst,
               (accept && cmd.kind == KIND_REMOVE) |=> !result_valid,
               "remove must give no beat")
  `PJTT_ASSERT(a_add_marks_busy, clk, rst,
               add_take |=> busy_bits[SLOT_W'(result.slot)],
               "added slot not marked busy")
  `PJTT_ASSERT(a_issue_to_eval, clk, rst,
               (state == S_SCAN && issue_active) |=> eval_valid,
               "issued read not evaluated")
  `PJTT_ASSERT_NEVER(a_idle_quiet, clk, rst,
                     state == S_IDLE && (eval_valid || issue_active || hold_valid),
                     "scan pipeline active while idle")

endmodule

`default_nettype wire
